@@ src/assert_macros.svh @@
// assertion macros included by the midi byte stream parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// concurrent check on the rising clock edge, also active during reset
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ src/mbsp_pkg.sv @@
// types, byte classes and the classify function of the midi byte parser
package mbsp_pkg;

  localparam logic [7:0] StatusBase  = 8'h80;
  localparam logic [7:0] SystemBase  = 8'hf0;
  localparam logic [2:0] VoiceMask   = 3'h7;
  localparam logic [3:0] CommonMask  = 4'hf;

  typedef enum logic [2:0] {
    CLS_DATA = 3'd0,
    CLS_LEN1 = 3'd1,
    CLS_LEN2 = 3'd2,
    CLS_LEN3 = 3'd3,
    CLS_RT   = 3'd4,
    CLS_RES  = 3'd5,
    CLS_SXS  = 3'd6,
    CLS_SXE  = 3'd7
  } byte_cls_t;

  typedef struct packed {
    logic       is_realtime;
    logic [7:0] status_out;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] msg_length;
  } result_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    c = CLS_DATA;
    if (b < StatusBase) begin
      c = CLS_DATA;
    end else if (b < SystemBase) begin
      case (b[6:4] & VoiceMask)
        3'd4, 3'd5: c = CLS_LEN2;
        default:    c = CLS_LEN3;
      endcase
    end else begin
      case (b[3:0] & CommonMask)
        4'h0:    c = CLS_SXS;
        4'h1:    c = CLS_LEN2;
        4'h2:    c = CLS_LEN3;
        4'h3:    c = CLS_LEN2;
        4'h6:    c = CLS_LEN1;
        4'h7:    c = CLS_SXE;
        4'h4, 4'h5, 4'h9, 4'hd: c = CLS_RES;
        default: c = CLS_RT;
      endcase
    end
    return c;
  endfunction

endpackage

@@ src/midi_byte_stream_parser.sv @@
// midi byte stream parser with running status, sysex filtering and realtime pass-through
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | rx_byte
//   out     | output    | out_valid/out_stall | is_realtime, status_out, first_data,
//           |           |                     | second_data, msg_length
//
// one byte per cycle while in_stall is low: the parse state updates in the cycle the beat is taken
// and a result is registered into the output register, or into the skid register while the output stalls
// a skid register holds a second result, so input is taken while one result waits
// in_stall rises only when both the output register and the skid register are full
// rst is synchronous and clears all parse state and both valid flags
module midi_byte_stream_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_realtime,
  output logic [7:0] status_out,
  output logic [6:0] first_data,
  output logic [6:0] second_data,
  output logic [1:0] msg_length
);
  import mbsp_pkg::*;

  logic [7:0] held_status, held_status_next;
  logic [6:0] held_first, held_first_next;
  logic [6:0] held_second, held_second_next;
  logic [1:0] expected_len, expected_len_next;
  logic [1:0] fill_offset, fill_offset_next;
  logic       in_sysex, in_sysex_next;

  result_t    res, out_reg, skid;
  logic       res_valid;
  logic       skid_valid;
  logic       in_fire, out_fire;
  byte_cls_t  cls;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~skid_valid;
  assign out_fire = out_valid & ~out_stall;

  always_comb begin
    cls               = classify(rx_byte);
    held_status_next  = held_status;
    held_first_next   = held_first;
    held_second_next  = held_second;
    expected_len_next = expected_len;
    fill_offset_next  = fill_offset;
    in_sysex_next     = in_sysex;
    res               = '0;
    res_valid         = 1'b0;

    if (cls == CLS_RT) begin
      res.is_realtime = 1'b1;
      res.status_out  = rx_byte;
      res.msg_length  = 2'd1;
      res_valid       = 1'b1;
    end else begin
      case (cls)
        CLS_DATA: begin
          if (!in_sysex) begin
            case (fill_offset)
              2'd0:    held_status_next = rx_byte;
              2'd1:    held_first_next  = rx_byte[6:0];
              2'd2:    held_second_next = rx_byte[6:0];
              default: ;
            endcase
            fill_offset_next = fill_offset + 2'd1;
          end
        end
        CLS_LEN1, CLS_LEN2, CLS_LEN3: begin
          held_status_next  = rx_byte;
          expected_len_next = cls[1:0];
          fill_offset_next  = 2'd1;
        end
        CLS_SXS: in_sysex_next = 1'b1;
        CLS_SXE: in_sysex_next = 1'b0;
        default: begin
          expected_len_next = 2'd0;
          fill_offset_next  = 2'd0;
        end
      endcase

      if (expected_len_next != 2'd0 && expected_len_next == fill_offset_next) begin
        res.is_realtime = 1'b0;
        res.status_out  = held_status_next;
        res.first_data  = (expected_len_next >= 2'd2) ? held_first_next : 7'd0;
        res.second_data = (expected_len_next == 2'd3) ? held_second_next : 7'd0;
        res.msg_length  = expected_len_next;
        res_valid       = 1'b1;
        if (expected_len_next == 2'd1) begin
          expected_len_next = 2'd0;
          fill_offset_next  = 2'd0;
        end else begin
          fill_offset_next = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_status  <= '0;
      held_first   <= '0;
      held_second  <= '0;
      expected_len <= '0;
      fill_offset  <= '0;
      in_sysex     <= 1'b0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        held_status  <= held_status_next;
        held_first   <= held_first_next;
        held_second  <= held_second_next;
        expected_len <= expected_len_next;
        fill_offset  <= fill_offset_next;
        in_sysex     <= in_sysex_next;
      end
      if (skid_valid) begin
        if (out_fire) begin
          out_reg    <= skid;
          skid_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid || out_fire) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid       <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign is_realtime = out_reg.is_realtime;
  assign status_out  = out_reg.status_out;
  assign first_data  = out_reg.first_data;
  assign second_data = out_reg.second_data;
  assign msg_length  = out_reg.msg_length;

`include "assert_macros.svh"

  `ASSERT_CLK(a_skid_needs_out, clk, rst, skid_valid |-> out_valid, "skid full while output empty")
  `ASSERT_CLK(a_offset_in_range, clk, rst, (expected_len != 2'd0) |-> (fill_offset != 2'd0 && fill_offset <= expected_len), "fill offset outside message")
  `ASSERT_CLK(a_rt_shape, clk, rst, (out_valid && is_realtime) |-> (msg_length == 2'd1 && first_data == 7'd0 && second_data == 7'd0), "bad realtime beat")
  `ASSERT_CLK(a_msg_len, clk, rst, (out_valid && !is_realtime) |-> (msg_length != 2'd0), "message beat with zero length")
  `ASSERT_CLK(a_held_out, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_reg)), "stalled result changed")

endmodule

@@ tb/midi_result_checker.sv @@
// checker for the midi byte parser: watches both channels, predicts results and compares them
module midi_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       is_realtime,
  input  logic [7:0] status_out,
  input  logic [6:0] first_data,
  input  logic [6:0] second_data,
  input  logic [1:0] msg_length,
  output int         error_count,
  output int         pending_results
);
  import mbsp_pkg::*;

  logic [7:0] msg_status;
  logic [6:0] msg_first;
  logic [6:0] msg_second;
  logic [1:0] msg_len;
  logic [1:0] slot;
  logic       sysex_open;

  result_t midi_expected_q[$];
  result_t want;
  result_t seen;

  function automatic byte_cls_t byte_kind(input logic [7:0] b);
    if (!b[7]) begin
      return CLS_DATA;
    end
    if (b[7:4] == 4'hc || b[7:4] == 4'hd) begin
      return CLS_LEN2;
    end
    if (b[7:4] != 4'hf) begin
      return CLS_LEN3;
    end
    case (b)
      8'hf0: return CLS_SXS;
      8'hf7: return CLS_SXE;
      8'hf6: return CLS_LEN1;
      8'hf1, 8'hf3: return CLS_LEN2;
      8'hf2: return CLS_LEN3;
      8'hf4, 8'hf5, 8'hf9, 8'hfd: return CLS_RES;
      default: return CLS_RT;
    endcase
  endfunction

  task automatic predict_midi_byte(input logic [7:0] b);
    byte_cls_t kind;
    result_t   r;
    kind = byte_kind(b);
    if (kind == CLS_RT) begin
      r.is_realtime = 1'b1;
      r.status_out  = b;
      r.first_data  = '0;
      r.second_data = '0;
      r.msg_length  = 2'd1;
      midi_expected_q.push_back(r);
      return;
    end
    case (kind)
      CLS_DATA: begin
        if (!sysex_open) begin
          case (slot)
            2'd0: msg_status = b;
            2'd1: msg_first = b[6:0];
            2'd2: msg_second = b[6:0];
            default: ;
          endcase
          slot = slot + 2'd1;
        end
      end
      CLS_LEN1, CLS_LEN2, CLS_LEN3: begin
        msg_status = b;
        msg_len = (kind == CLS_LEN1) ? 2'd1 : (kind == CLS_LEN2) ? 2'd2 : 2'd3;
        slot = 2'd1;
      end
      CLS_SXS: sysex_open = 1'b1;
      CLS_SXE: sysex_open = 1'b0;
      default: begin
        msg_len = 2'd0;
        slot = 2'd0;
      end
    endcase
    if (msg_len != 2'd0 && msg_len == slot) begin
      r.is_realtime = 1'b0;
      r.status_out  = msg_status;
      r.first_data  = (msg_len >= 2'd2) ? msg_first : 7'd0;
      r.second_data = (msg_len == 2'd3) ? msg_second : 7'd0;
      r.msg_length  = msg_len;
      midi_expected_q.push_back(r);
      if (msg_len == 2'd1) begin
        msg_len = 2'd0;
        slot = 2'd0;
      end else begin
        slot = 2'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      msg_status  = '0;
      msg_first   = '0;
      msg_second  = '0;
      msg_len     = '0;
      slot        = '0;
      sysex_open  = 1'b0;
      error_count = 0;
      midi_expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.is_realtime = is_realtime;
        seen.status_out  = status_out;
        seen.first_data  = first_data;
        seen.second_data = second_data;
        seen.msg_length  = msg_length;
        if (midi_expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat, expected none actual %0h", $time, seen);
        end else begin
          want = midi_expected_q.pop_front();
          check_field("is_realtime", want.is_realtime, seen.is_realtime);
          check_field("status_out", want.status_out, seen.status_out);
          check_field("first_data", want.first_data, seen.first_data);
          check_field("second_data", want.second_data, seen.second_data);
          check_field("msg_length", want.msg_length, seen.msg_length);
        end
      end
      if (in_valid && !in_stall) begin
        predict_midi_byte(rx_byte);
      end
    end
    pending_results <= midi_expected_q.size();
  end

endmodule

@@ tb/midi_byte_stream_parser_tb.sv @@
// testbench top for the midi byte parser: clock, reset, byte stimulus and verdict
module midi_byte_stream_parser_tb;

  localparam logic [7:0] SX_OPEN      = 8'hf0;
  localparam logic [7:0] SX_CLOSE     = 8'hf7;
  localparam logic [7:0] TUNE_REQUEST = 8'hf6;
  localparam logic [7:0] REALTIME_BYTES [6] = '{8'hf8, 8'hfa, 8'hfb, 8'hfc, 8'hfe, 8'hff};
  localparam logic [7:0] RESERVED_BYTES [4] = '{8'hf4, 8'hf5, 8'hf9, 8'hfd};
  localparam logic [7:0] COMMON_STATUS [4] = '{8'hf1, 8'hf2, 8'hf3, TUNE_REQUEST};
  localparam int RANDOM_ITEMS = 515;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       is_realtime;
  logic [7:0] status_out;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic [1:0] msg_length;
  int         error_count;
  int         pending_results;

  int send_idle_pct;
  int recv_idle_pct;
  int item_count;

  midi_byte_stream_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_realtime (is_realtime),
    .status_out  (status_out),
    .first_data  (first_data),
    .second_data (second_data),
    .msg_length  (msg_length)
  );

  midi_result_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .is_realtime     (is_realtime),
    .status_out      (status_out),
    .first_data      (first_data),
    .second_data     (second_data),
    .msg_length      (msg_length),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #800000;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (counted) item_count++;
  endtask

  function automatic int data_bytes_for(input logic [7:0] st);
    if (st == TUNE_REQUEST) return 0;
    if (st[7:4] == 4'hc || st[7:4] == 4'hd || st == 8'hf1 || st == 8'hf3) return 1;
    return 2;
  endfunction

  function automatic logic [7:0] pick_status();
    if ($urandom_range(4) == 0) return COMMON_STATUS[$urandom_range(3)];
    return {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
  endfunction

  task automatic send_message();
    int         kind;
    int         reps;
    int         n;
    logic [7:0] st;
    kind = $urandom_range(99);
    if (kind < 55) begin
      st = pick_status();
      send_byte(st, 1'b1);
      reps = (st == TUNE_REQUEST) ? 0 : $urandom_range(1, 4);
      for (int r = 0; r < reps; r++) begin
        for (int d = 0; d < data_bytes_for(st); d++) begin
          if ($urandom_range(9) == 0) send_byte(REALTIME_BYTES[$urandom_range(5)], 1'b1);
          send_byte(8'($urandom_range(127)), 1'b1);
        end
      end
    end else if (kind < 70) begin
      send_byte(SX_OPEN, 1'b1);
      n = $urandom_range(1, 6);
      for (int d = 0; d < n; d++) begin
        if ($urandom_range(7) == 0) send_byte(pick_status(), 1'b1);
        else send_byte(8'($urandom_range(127)), 1'b1);
      end
      send_byte(SX_CLOSE, 1'b1);
    end else if (kind < 80) begin
      send_byte(REALTIME_BYTES[$urandom_range(5)], 1'b1);
    end else if (kind < 90) begin
      st = pick_status();
      send_byte(st, 1'b1);
      if (data_bytes_for(st) == 2) send_byte(8'($urandom_range(127)), 1'b1);
      if ($urandom_range(1) == 0) send_byte(RESERVED_BYTES[$urandom_range(3)], 1'b1);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    rx_byte       = '0;
    send_idle_pct = 18;
    recv_idle_pct = 66;
    item_count    = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // data with no message, wrap past slot three
    send_byte(8'h00, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'h2a, 1'b1);
    foreach (REALTIME_BYTES[i]) send_byte(REALTIME_BYTES[i], 1'b1);
    // note on plus running status
    send_byte(8'h90, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h40, 1'b1);
    send_byte(8'h7f, 1'b1);
    // reserved byte mid message
    send_byte(8'hc5, 1'b1);
    send_byte(8'hf4, 1'b1);
    send_byte(8'h12, 1'b1);
    send_byte(TUNE_REQUEST, 1'b1);
    send_byte(8'h33, 1'b1);
    // status inside sysex
    send_byte(SX_OPEN, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(SX_CLOSE, 1'b1);
    send_byte(8'hf1, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'hef, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b1);
    foreach (RESERVED_BYTES[i]) send_byte(RESERVED_BYTES[i], 1'b1);

    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      if (item_count < RANDOM_ITEMS / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 66;
      end else if (item_count < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_message();
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mbsp_pkg.sv
src/midi_byte_stream_parser.sv
tb/midi_result_checker.sv
tb/midi_byte_stream_parser_tb.sv
